// File: rtl/sao_pkg.sv
`default_nettype none
package sao_pkg;

  localparam int POOL_SLOTS_DEF = 16;
  localparam int SLOT_W         = 4;
  localparam int STATUS_W       = 2;
  localparam int TIME_W         = 32;
  // 2.0 s in 1 ms ticks
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd2000;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_REFRESH = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_SWEEP   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DEAD  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_UPD,
    S_SW_RD,
    S_SW_CHK,
    S_CLOSE
  } sao_state_t;

endpackage
`default_nettype wire

// File: rtl/sao_req_if.sv
`default_nettype none
interface sao_req_if import sao_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [SLOT_W-1:0] slot;
  logic [TIME_W-1:0] now;

  modport source (output valid, req_type, slot, now, input ready);
  modport sink (input valid, req_type, slot, now, output ready);
endinterface
`default_nettype wire

// File: rtl/sao_res_if.sv
`default_nettype none
interface sao_res_if import sao_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot_id;
  logic [STATUS_W-1:0] status;
  logic                evicted;
  logic                last;

  modport source (output valid, slot_id, status, evicted, last, input ready);
  modport sink (input valid, slot_id, status, evicted, last, output ready);
endinterface
`default_nettype wire

// File: rtl/sao_stamp_ram.sv
`default_nettype none
module sao_stamp_ram import sao_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF,
  localparam int IDW = $clog2(POOL_SLOTS)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [IDW-1:0]    waddr,
  input  wire logic [TIME_W-1:0] wdata,
  input  wire logic [IDW-1:0]    raddr,
  output logic      [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0] mem [POOL_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/sao_free_fifo.sv
`default_nettype none
module sao_free_fifo import sao_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF,
  localparam int IDW = $clog2(POOL_SLOTS),
  localparam int CW  = $clog2(POOL_SLOTS + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire logic [IDW-1:0] push_id,
  input  wire logic           pop,
  output logic      [IDW-1:0] head_id,
  output logic      [CW-1:0]  count
);

  logic [IDW-1:0] mem [POOL_SLOTS];
  logic [IDW-1:0] head;
  logic [CW:0]    tail_sum;
  logic [IDW-1:0] tail;
  logic [IDW:0]   head_inc;

  always_comb begin
    tail_sum = {{(CW + 1 - IDW){1'b0}}, head} + {1'b0, count};
    if (tail_sum >= (CW + 1)'(POOL_SLOTS)) begin
      tail_sum = tail_sum - (CW + 1)'(POOL_SLOTS);
    end
    tail = tail_sum[IDW-1:0];
    head_inc = {1'b0, head} + 1'b1;
    if (head_inc >= (IDW + 1)'(POOL_SLOTS)) begin
      head_inc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && count < CW'(POOL_SLOTS)) begin
      mem[tail] <= push_id;
    end
    head_id <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (pop) begin
      head  <= head_inc[IDW-1:0];
      count <= count - 1'b1;
    end else if (push && count < CW'(POOL_SLOTS)) begin
      count <= count + 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/slot_allocator_with_timeout_aging.sv
`default_nettype none
// Slot allocator with timeout aging. Requests allocate, refresh, release or
// sweep a pool of POOL_SLOTS slots; released and evicted ids are reused in
// FIFO order before the pool grows. One request is in work at a time and
// req.ready is high only while the sequencer is idle. Allocate, refresh and
// release present their result from their own state once the output
// register is free, then return to idle for the next request. A sweep
// walks the N ids grown so far: each slot is read on the single stamp
// memory read port in S_SW_RD and checked by the age comparator in
// S_SW_CHK; each eviction beat waits for the output register. Results sit
// in one output register, and a stalled sink holds back the next beat.
// timeout_ticks resets to 2000 and is written through cfg_we/cfg_data.
module slot_allocator_with_timeout_aging import sao_pkg::*; #(
  parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  sao_req_if.sink                req,
  sao_res_if.source              res,
  input  wire logic              cfg_we,
  input  wire logic [TIME_W-1:0] cfg_data
);

  localparam int IDW = $clog2(POOL_SLOTS);
  localparam int CW  = $clog2(POOL_SLOTS + 1);

  sao_state_t state, state_next;

  logic [TIME_W-1:0]  timeout_ticks;
  logic [1:0]         req_type_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [TIME_W-1:0]  now_q;
  logic [POOL_SLOTS-1:0] slot_live;
  logic [CW-1:0]      grown_count;
  logic [CW-1:0]      idx, idx_next;

  logic               res_valid;
  logic               out_free;
  logic               emit;
  logic [SLOT_W-1:0]  e_slot;
  status_t            e_status;
  logic               e_evicted;
  logic               e_last;

  logic               live_set, live_clr;
  logic [IDW-1:0]     live_idx;
  logic               stamp_we;
  logic [IDW-1:0]     stamp_waddr;
  logic [TIME_W-1:0]  stamp_rdata;
  logic               push, pop, grown_inc;
  logic [IDW-1:0]     push_id;
  logic [IDW-1:0]     head_id;
  logic [CW-1:0]      free_count;

  logic [IDW-1:0]     alloc_id;
  logic [IDW+3:0]     alloc_ext;
  logic [IDW+3:0]     sweep_ext;
  logic [CW+3:0]      slot_w;
  logic [CW+3:0]      grown_w;
  logic [IDW-1:0]     slot_idx;
  logic [IDW-1:0]     sw_idx;
  logic               range_err;
  logic [TIME_W-1:0]  age;
  logic               expired;

  assign req.ready = (state == S_IDLE);
  assign out_free  = !res_valid || res.ready;

  sao_stamp_ram #(.POOL_SLOTS(POOL_SLOTS)) u_stamp (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (now_q),
    .raddr (sw_idx),
    .rdata (stamp_rdata)
  );

  sao_free_fifo #(.POOL_SLOTS(POOL_SLOTS)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_id (push_id),
    .pop     (pop),
    .head_id (head_id),
    .count   (free_count)
  );

  always_comb begin
    alloc_id  = (free_count != '0) ? head_id : grown_count[IDW-1:0];
    alloc_ext = {4'b0000, alloc_id};
    sw_idx    = idx[IDW-1:0];
    sweep_ext = {4'b0000, sw_idx};
    slot_w    = {{CW{1'b0}}, slot_q};
    grown_w   = {4'b0000, grown_count};
    slot_idx  = slot_w[IDW-1:0];
    range_err = (slot_w >= grown_w);
    // wrapping age against the stamp read in the previous cycle
    age       = now_q - stamp_rdata;
    expired   = slot_live[sw_idx] && (age > timeout_ticks);
  end

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    emit        = 1'b0;
    e_slot      = '0;
    e_status    = ST_OK;
    e_evicted   = 1'b0;
    e_last      = 1'b1;
    live_set    = 1'b0;
    live_clr    = 1'b0;
    live_idx    = slot_idx;
    stamp_we    = 1'b0;
    stamp_waddr = slot_idx;
    push        = 1'b0;
    push_id     = slot_idx;
    pop         = 1'b0;
    grown_inc   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          unique case (req.req_type) inside
            REQ_ALLOC: state_next = S_ALLOC;
            REQ_REFRESH, REQ_RELEASE: state_next = S_UPD;
            default: begin
              state_next = S_SW_RD;
              idx_next   = '0;
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (free_count == '0 && grown_count >= CW'(POOL_SLOTS)) begin
            e_status = ST_FULL;
          end else begin
            pop         = (free_count != '0);
            grown_inc   = (free_count == '0);
            live_set    = 1'b1;
            live_idx    = alloc_id;
            stamp_we    = 1'b1;
            stamp_waddr = alloc_id;
            e_slot      = alloc_ext[SLOT_W-1:0];
          end
        end
      end

      S_UPD: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          e_slot     = slot_q;
          if (range_err) begin
            e_status = ST_RANGE;
          end else if (!slot_live[slot_idx]) begin
            e_status = ST_DEAD;
          end else if (req_type_q == REQ_REFRESH) begin
            stamp_we = 1'b1;
          end else begin
            live_clr = 1'b1;
            push     = 1'b1;
          end
        end
      end

      S_SW_RD: begin
        if (idx >= grown_count) begin
          state_next = S_CLOSE;
        end else begin
          state_next = S_SW_CHK;
        end
      end

      S_SW_CHK: begin
        live_idx = sw_idx;
        push_id  = sw_idx;
        if (!expired) begin
          idx_next   = idx + 1'b1;
          state_next = S_SW_RD;
        end else if (out_free) begin
          emit       = 1'b1;
          e_slot     = sweep_ext[SLOT_W-1:0];
          e_evicted  = 1'b1;
          e_last     = 1'b0;
          live_clr   = 1'b1;
          push       = 1'b1;
          idx_next   = idx + 1'b1;
          state_next = S_SW_RD;
        end
      end

      S_CLOSE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= '0;
      grown_count   <= '0;
      slot_live     <= '0;
      timeout_ticks <= TIMEOUT_RESET;
    end else begin
      idx <= idx_next;
      if (grown_inc) begin
        grown_count <= grown_count + 1'b1;
      end
      if (live_set) begin
        slot_live[live_idx] <= 1'b1;
      end else if (live_clr) begin
        slot_live[live_idx] <= 1'b0;
      end
      if (cfg_we) begin
        timeout_ticks <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_type_q <= req.req_type;
      slot_q     <= req.slot;
      now_q      <= req.now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.slot_id <= e_slot;
      res.status  <= e_status;
      res.evicted <= e_evicted;
      res.last    <= e_last;
    end
  end

  assign res.valid = res_valid;

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb import sao_pkg::*; ();

  localparam int NSLOT        = POOL_SLOTS_DEF;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 2 * NSLOT + 8;
  localparam int LONG_HOLD    = 300;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_id;
    status_t           status;
    logic              evicted;
    logic              last;
  } beat_t;

  typedef struct {
    bit    pinned;
    beat_t beat;
  } pin_t;

  typedef struct {
    req_t              kind;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now;
    bit                pinned;
    logic [SLOT_W-1:0] id;
    status_t           status;
  } row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [TIME_W-1:0] cfg_data;

  sao_req_if req_bus ();
  sao_res_if res_bus ();

  slot_allocator_with_timeout_aging u_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_bus),
    .res      (res_bus),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // pool model
  logic [TIME_W-1:0] aging_limit = TIMEOUT_RESET;
  bit                live_bits [NSLOT];
  logic [TIME_W-1:0] stamps [NSLOT];
  logic [SLOT_W-1:0] free_ids [NSLOT];
  int                free_rd;
  int                free_len;
  int                grown;

  beat_t             expected_beats [$];
  pin_t              pins [$];
  int                mismatches;
  int                cycles;
  bit                gaps_on = 1'b1;
  bit                hold_req;
  logic [TIME_W-1:0] wall;
  row_t              script [15];

  function automatic void recycle_id(int id);
    if (free_len < NSLOT) begin
      free_ids[(free_rd + free_len) % NSLOT] = SLOT_W'(id);
      free_len++;
    end
  endfunction

  function automatic void predict_request(req_t kind, logic [SLOT_W-1:0] sl,
                                          logic [TIME_W-1:0] t);
    int                id;
    bit                got_id;
    logic [TIME_W-1:0] age;
    got_id = 1'b1;
    id = 0;
    case (kind)
      REQ_ALLOC: begin
        if (free_len > 0) begin
          id = free_ids[free_rd];
          free_rd = (free_rd + 1) % NSLOT;
          free_len--;
        end else if (grown < NSLOT) begin
          id = grown;
          grown++;
        end else begin
          got_id = 1'b0;
        end
        if (got_id) begin
          live_bits[id] = 1'b1;
          stamps[id] = t;
          expected_beats.push_back(beat_t'{SLOT_W'(id), ST_OK, 1'b0, 1'b1});
        end else begin
          expected_beats.push_back(beat_t'{'0, ST_FULL, 1'b0, 1'b1});
        end
      end
      REQ_REFRESH, REQ_RELEASE: begin
        if (int'(sl) >= grown) begin
          expected_beats.push_back(beat_t'{sl, ST_RANGE, 1'b0, 1'b1});
        end else if (!live_bits[sl]) begin
          expected_beats.push_back(beat_t'{sl, ST_DEAD, 1'b0, 1'b1});
        end else begin
          if (kind == REQ_REFRESH) begin
            stamps[sl] = t;
          end else begin
            live_bits[sl] = 1'b0;
            recycle_id(sl);
          end
          expected_beats.push_back(beat_t'{sl, ST_OK, 1'b0, 1'b1});
        end
      end
      default: begin
        for (int i = 0; i < grown; i++) begin
          age = t - stamps[i];
          if (live_bits[i] && age > aging_limit) begin
            live_bits[i] = 1'b0;
            recycle_id(i);
            expected_beats.push_back(beat_t'{SLOT_W'(i), ST_OK, 1'b1, 1'b0});
          end
        end
        expected_beats.push_back(beat_t'{'0, ST_OK, 1'b0, 1'b1});
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // scoreboard: check result beats, predict accepted requests
  always @(posedge clk) begin
    beat_t want;
    pin_t  pin;
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end else if (!rst) begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: slot_id %0d status %0d evicted %0d last %0d",
                 res_bus.slot_id, res_bus.status, res_bus.evicted, res_bus.last);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          check_field("slot_id", 8'(want.slot_id), 8'(res_bus.slot_id));
          check_field("status", 8'(want.status), 8'(res_bus.status));
          check_field("evicted", 8'(want.evicted), 8'(res_bus.evicted));
          check_field("last", 8'(want.last), 8'(res_bus.last));
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        pin = pins.pop_front();
        predict_request(req_t'(req_bus.req_type), req_bus.slot, req_bus.now);
        // hand-typed expectation replaces the predicted single beat
        if (pin.pinned)
          expected_beats[expected_beats.size() - 1] = pin.beat;
      end
    end
  end

  // receiver: short random stalls, one long hold on request
  initial begin
    res_bus.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        res_bus.ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        res_bus.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(req_t kind, logic [SLOT_W-1:0] sl, logic [TIME_W-1:0] t,
                           bit pinned, beat_t want);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pins.push_back('{pinned, want});
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.slot     <= sl;
    req_bus.now      <= t;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  function automatic logic [SLOT_W-1:0] pick_live(logic [SLOT_W-1:0] start);
    logic [SLOT_W-1:0] idx;
    for (int k = 0; k < NSLOT; k++) begin
      idx = SLOT_W'((int'(start) + k) % NSLOT);
      if (live_bits[idx])
        return idx;
    end
    return start;
  endfunction

  task automatic random_item(int alloc_pct, int max_step);
    int                roll;
    int                rest;
    req_t              kind;
    logic [SLOT_W-1:0] sl;
    logic [TIME_W-1:0] t;
    roll = $urandom_range(0, 99);
    rest = 100 - alloc_pct;
    if (roll < alloc_pct)
      kind = REQ_ALLOC;
    else if (roll < alloc_pct + rest * 2 / 5)
      kind = REQ_REFRESH;
    else if (roll < alloc_pct + rest * 4 / 5)
      kind = REQ_RELEASE;
    else
      kind = REQ_SWEEP;
    sl = SLOT_W'($urandom_range(0, NSLOT - 1));
    // mostly target live slots so refresh and release get past the checks
    if ((kind == REQ_REFRESH || kind == REQ_RELEASE) && $urandom_range(0, 3) != 0)
      sl = pick_live(sl);
    wall += $urandom_range(0, max_step);
    t = ($urandom_range(0, 15) == 0) ? TIME_W'($urandom()) : wall;
    send_item(kind, sl, t, 1'b0, '0);
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [TIME_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    aging_limit = v;
  endtask

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_data         <= '0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_ALLOC;
    req_bus.slot     <= '0;
    req_bus.now      <= '0;

    script = '{
      '{REQ_REFRESH, 4'd0,  32'd0,          1'b1, 4'd0,  ST_RANGE},
      '{REQ_RELEASE, 4'd15, 32'd0,          1'b1, 4'd15, ST_RANGE},
      '{REQ_SWEEP,   4'd9,  32'd0,          1'b0, 4'd0,  ST_OK},
      '{REQ_ALLOC,   4'd0,  32'd0,          1'b1, 4'd0,  ST_OK},
      '{REQ_ALLOC,   4'd15, 32'hFFFF_FFFF,  1'b1, 4'd1,  ST_OK},
      '{REQ_REFRESH, 4'd1,  32'd100,        1'b1, 4'd1,  ST_OK},
      '{REQ_RELEASE, 4'd0,  32'd100,        1'b1, 4'd0,  ST_OK},
      '{REQ_RELEASE, 4'd0,  32'd110,        1'b1, 4'd0,  ST_DEAD},
      '{REQ_REFRESH, 4'd0,  32'd120,        1'b1, 4'd0,  ST_DEAD},
      '{REQ_REFRESH, 4'd2,  32'd130,        1'b1, 4'd2,  ST_RANGE},
      '{REQ_ALLOC,   4'd7,  32'd200,        1'b1, 4'd0,  ST_OK},
      '{REQ_ALLOC,   4'd7,  32'd300,        1'b1, 4'd2,  ST_OK},
      // slots 0 and 1 past the 2000 tick limit, slot 2 exactly at it
      '{REQ_SWEEP,   4'd0,  32'd2300,       1'b0, 4'd0,  ST_OK},
      '{REQ_SWEEP,   4'd0,  32'd2301,       1'b0, 4'd0,  ST_OK},
      '{REQ_ALLOC,   4'd0,  32'd2400,       1'b1, 4'd0,  ST_OK}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i])
      send_item(script[i].kind, script[i].slot, script[i].now, script[i].pinned,
                beat_t'{script[i].id, script[i].status, 1'b0, 1'b1});

    // zero timeout, time starting just below the wrap point
    drain();
    write_timeout('0);
    wall = 32'hFFFF_FFC0;
    repeat (35) random_item(40, 3);

    // max timeout: nothing ever ages out; fill the pool under a long output hold
    drain();
    write_timeout('1);
    hold_req = 1'b1;
    repeat (NSLOT + 1) begin
      wall += $urandom_range(0, 50);
      send_item(REQ_ALLOC, SLOT_W'($urandom_range(0, NSLOT - 1)), wall, 1'b0, '0);
    end
    repeat (20) random_item(50, 100000);

    // small random timeout
    drain();
    write_timeout(TIME_W'($urandom_range(1, 60)));
    repeat (20) random_item(40, 20);
    gaps_on = 1'b0;
    repeat (25) random_item(40, 20);

    drain();
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
